// File: src/gfsr_pkg.sv
// Package for the gear-from-speed-and-rpm unit: field widths, fixed
// arithmetic constants, gear codes, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package gfsr_pkg;

    // Field widths
    localparam int unsigned SPD_W   = 8;
    localparam int unsigned RPM_W   = 16;
    localparam int unsigned DIR_W   = 8;
    localparam int unsigned RATIO_W = 16;
    localparam int unsigned GEAR_W  = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // rpm * 10000 fits in 30 bits (65535 * 10000 < 2**30)
    localparam int unsigned RPM_SCALE = 10000;
    localparam int unsigned NUM_W     = 30;

    // ratio = (q * 27) / 209, saturated at 65535
    localparam int unsigned RATIO_MUL = 27;
    localparam int unsigned RATIO_DIV = 209;
    localparam longint unsigned RATIO_MAX_VAL = 65535;
    // smallest quotient whose scaled ratio reaches the saturation value
    localparam longint unsigned SAT_LIMIT =
        (RATIO_MAX_VAL * RATIO_DIV + RATIO_MUL - 1) / RATIO_MUL;
    // quotient bits kept below the limit, and width of q * 27 there
    localparam int unsigned QS_W     = 19;
    localparam int unsigned SCALED_W = 24;

    // division by 209 as multiply by ceil(2**32 / 209), exact for x < 2**24
    localparam int unsigned RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_SHIFT) + RATIO_DIV - 1) / RATIO_DIV;
    localparam int unsigned RECIP_W = 25;
    localparam int unsigned PROD_W  = SCALED_W + RECIP_W;

    // Codes
    localparam logic [DIR_W-1:0]   DIR_REVERSE  = 8'h04;
    localparam logic [GEAR_W-1:0]  GEAR_REVERSE = 8'hFE;
    localparam logic [GEAR_W-1:0]  GEAR_UNKNOWN = 8'hFF;
    localparam logic [RATIO_W-1:0] RATIO_MAX    = 16'hFFFF;
    localparam int unsigned LADDER_N = 6;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_GEAR_MAX    = 3'd0,
        CFG_REVERSE_THRESHOLD = 3'd1,
        CFG_THRESHOLD_FIRST   = 3'd2,
        CFG_THRESHOLD_SECOND  = 3'd3,
        CFG_THRESHOLD_THIRD   = 3'd4,
        CFG_THRESHOLD_FOURTH  = 3'd5,
        CFG_THRESHOLD_FIFTH   = 3'd6,
        CFG_THRESHOLD_SIXTH   = 3'd7
    } t_cfg_idx;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] RST_FIRST_GEAR_MAX    = 16'd432;
    localparam logic [CFG_W-1:0] RST_REVERSE_THRESHOLD = 16'd300;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_FIRST   = 16'd294;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_SECOND  = 16'd168;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_THIRD   = 16'd113;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_FOURTH  = 16'd85;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_FIFTH   = 16'd68;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_SIXTH   = 16'd50;

    // Flags that travel with an item
    typedef struct packed {
        logic rev;   // direction is reverse
        logic zero;  // vehicle standing, ratio forced to 0
    } t_side;

    // Threshold set seen by the gear decision
    typedef struct packed {
        logic [CFG_W-1:0]                first_max;
        logic [CFG_W-1:0]                rev_thr;
        logic [LADDER_N-1:0][CFG_W-1:0]  ladder;
    } t_cfg;

endpackage

// File: src/gfsr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gfsr_pkg (t_side).
`timescale 1ns / 1ps

module gfsr_div #(
    parameter int unsigned NUM_W = 30,
    parameter int unsigned DEN_W = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    input  gfsr_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [NUM_W-1:0]    o_quo,
    output gfsr_pkg::t_side     o_side
);
    import gfsr_pkg::*;

    // Per-stage registers; stage k holds the state after k+1 quotient bits
    logic              r_v    [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];  // dividend bits left, quotient bits in
    logic [DEN_W-1:0]  r_den  [NUM_W];
    t_side             r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              a_v;
        logic [DEN_W-1:0]  a_rem;
        logic [NUM_W-1:0]  a_nq;
        logic [DEN_W-1:0]  a_den;
        t_side             a_side;
        logic [DEN_W:0]    w_trial;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_rem  = '0;
            assign a_nq   = i_num;
            assign a_den  = i_den;
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_nq   = r_nq[k-1];
            assign a_den  = r_den[k-1];
            assign a_side = r_side[k-1];
        end

        // shift in the next dividend bit and try a subtract
        assign w_trial = {a_rem, a_nq[NUM_W-1]};
        assign w_diff  = w_trial - {1'b0, a_den};
        assign w_ge    = (w_trial >= {1'b0, a_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_nq[k]   <= {a_nq[NUM_W-2:0], w_ge};
                r_den[k]  <= a_den;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// File: src/gfsr_scale.sv
// Ratio scaling: q * 27 / 209 with saturation, in two register stages.
// Depends on gfsr_pkg (widths, constants, t_side).
`timescale 1ns / 1ps

module gfsr_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [gfsr_pkg::NUM_W-1:0]      i_quo,
    input  gfsr_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [gfsr_pkg::RATIO_W-1:0]    o_ratio,
    output logic                            o_rev
);
    import gfsr_pkg::*;

    logic                 r_s1_v;
    logic                 r_s1_sat;
    logic                 r_s1_rev;
    logic [SCALED_W-1:0]  r_s1_x;
    logic                 r_s2_v;
    logic                 r_s2_rev;
    logic [RATIO_W-1:0]   r_s2_ratio;

    logic                 w_sat;
    logic [SCALED_W-1:0]  w_x;
    logic [PROD_W-1:0]    w_prod;

    // Stage 1: saturation test and multiply by 27 (standing vehicle gives 0)
    assign w_sat = !i_side.zero && (i_quo >= NUM_W'(SAT_LIMIT));
    assign w_x   = i_side.zero ? '0
                 : SCALED_W'(i_quo[QS_W-1:0]) * SCALED_W'(RATIO_MUL);

    // Stage 2: divide by 209 through the reciprocal product
    assign w_prod = PROD_W'(r_s1_x) * PROD_W'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_sat   <= w_sat;
            r_s1_rev   <= i_side.rev;
            r_s1_x     <= w_x;
            r_s2_rev   <= r_s1_rev;
            r_s2_ratio <= r_s1_sat ? RATIO_MAX : w_prod[RECIP_SHIFT +: RATIO_W];
        end
    end

    assign o_valid = r_s2_v;
    assign o_ratio = r_s2_ratio;
    assign o_rev   = r_s2_rev;

endmodule

// File: src/gfsr_gear.sv
// Gear decision: reverse test or threshold ladder over the ratio.
// Depends on gfsr_pkg (widths, gear codes, t_cfg).
`timescale 1ns / 1ps

module gfsr_gear (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [gfsr_pkg::RATIO_W-1:0]    i_ratio,
    input  logic                            i_rev,
    input  gfsr_pkg::t_cfg                  i_cfg,
    output logic                            o_valid,
    output logic [gfsr_pkg::RATIO_W-1:0]    o_ratio,
    output logic [gfsr_pkg::GEAR_W-1:0]     o_gear
);
    import gfsr_pkg::*;

    logic                r_v;
    logic [RATIO_W-1:0]  r_ratio;
    logic [GEAR_W-1:0]   r_gear;
    logic [GEAR_W-1:0]   w_gear;
    logic                w_found;

    // First passing test decides, in register order
    always_comb begin
        w_gear  = GEAR_UNKNOWN;
        w_found = 1'b0;
        if (i_rev) begin
            w_gear = (i_ratio > i_cfg.rev_thr) ? GEAR_REVERSE : GEAR_UNKNOWN;
        end else if (i_ratio > i_cfg.first_max) begin
            w_gear = GEAR_UNKNOWN;
        end else begin
            for (int k = 0; k < LADDER_N; k++) begin
                if (!w_found && (i_ratio > i_cfg.ladder[k])) begin
                    w_gear  = GEAR_W'(k + 1);
                    w_found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ratio <= i_ratio;
            r_gear  <= w_gear;
        end
    end

    assign o_valid = r_v;
    assign o_ratio = r_ratio;
    assign o_gear  = r_gear;

endmodule

// File: src/gear_from_speed_and_rpm_unit.sv
// Top level of the gear-from-speed-and-rpm unit: front multipliers,
// registers, output stage and skid. Uses gfsr_pkg, gfsr_div, gfsr_scale, gfsr_gear.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_valid / o_ready    | i_vehicle_speed, i_engine_speed,
//           |                      | i_direction_code
//  output   | o_valid / i_ready    | o_ratio_x100, o_gear_number
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One item per cycle while the skid register is empty. Stages: front multiply, one
// divider stage per quotient bit (30), two scaling stages, gear, output register.
// Synchronous active-low reset clears all valid bits and loads default thresholds.
// The pipeline advances as a whole while the skid register is empty, so input
// is taken even while a result waits at the output; a stall of i_ready
// fills the skid and then holds the pipeline.
`timescale 1ns / 1ps

module gear_from_speed_and_rpm_unit #(
    parameter int unsigned AXLE_RATIO_X100 = 394
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [gfsr_pkg::SPD_W-1:0]        i_vehicle_speed,
    input  logic [gfsr_pkg::RPM_W-1:0]        i_engine_speed,
    input  logic [gfsr_pkg::DIR_W-1:0]        i_direction_code,
    // output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [gfsr_pkg::RATIO_W-1:0]      o_ratio_x100,
    output logic [gfsr_pkg::GEAR_W-1:0]       o_gear_number,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [gfsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gfsr_pkg::CFG_W-1:0]        i_cfg_data
);
    import gfsr_pkg::*;

    localparam int unsigned AXLE_W = $clog2(AXLE_RATIO_X100 + 1);
    localparam int unsigned DEN_W  = SPD_W + AXLE_W;

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_max <= RST_FIRST_GEAR_MAX;
            r_cfg.rev_thr   <= RST_REVERSE_THRESHOLD;
            r_cfg.ladder[0] <= RST_THRESHOLD_FIRST;
            r_cfg.ladder[1] <= RST_THRESHOLD_SECOND;
            r_cfg.ladder[2] <= RST_THRESHOLD_THIRD;
            r_cfg.ladder[3] <= RST_THRESHOLD_FOURTH;
            r_cfg.ladder[4] <= RST_THRESHOLD_FIFTH;
            r_cfg.ladder[5] <= RST_THRESHOLD_SIXTH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_GEAR_MAX:    r_cfg.first_max <= i_cfg_data;
                CFG_REVERSE_THRESHOLD: r_cfg.rev_thr   <= i_cfg_data;
                CFG_THRESHOLD_FIRST:   r_cfg.ladder[0] <= i_cfg_data;
                CFG_THRESHOLD_SECOND:  r_cfg.ladder[1] <= i_cfg_data;
                CFG_THRESHOLD_THIRD:   r_cfg.ladder[2] <= i_cfg_data;
                CFG_THRESHOLD_FOURTH:  r_cfg.ladder[3] <= i_cfg_data;
                CFG_THRESHOLD_FIFTH:   r_cfg.ladder[4] <= i_cfg_data;
                CFG_THRESHOLD_SIXTH:   r_cfg.ladder[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline enable: held only while the skid register is occupied
    logic r_skid_v;
    logic w_en;

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    // Front stage: numerator rpm*10000, denominator speed*axle, flags
    logic              r_f_v;
    logic [NUM_W-1:0]  r_f_num;
    logic [DEN_W-1:0]  r_f_den;
    t_side             r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_num       <= NUM_W'(i_engine_speed) * NUM_W'(RPM_SCALE);
            r_f_den       <= DEN_W'(i_vehicle_speed) * DEN_W'(AXLE_RATIO_X100);
            r_f_side.rev  <= (i_direction_code == DIR_REVERSE);
            r_f_side.zero <= (i_vehicle_speed == '0);
        end
    end

    // Divider
    logic              w_d_v;
    logic [NUM_W-1:0]  w_d_quo;
    t_side             w_d_side;

    gfsr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f_v),
        .i_num   (r_f_num),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (w_d_v),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    // Scaling and saturation
    logic                w_s_v;
    logic [RATIO_W-1:0]  w_s_ratio;
    logic                w_s_rev;

    gfsr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_quo   (w_d_quo),
        .i_side  (w_d_side),
        .o_valid (w_s_v),
        .o_ratio (w_s_ratio),
        .o_rev   (w_s_rev)
    );

    // Gear decision
    logic                w_g_v;
    logic [RATIO_W-1:0]  w_g_ratio;
    logic [GEAR_W-1:0]   w_g_gear;

    gfsr_gear u_gear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_v),
        .i_ratio (w_s_ratio),
        .i_rev   (w_s_rev),
        .i_cfg   (r_cfg),
        .o_valid (w_g_v),
        .o_ratio (w_g_ratio),
        .o_gear  (w_g_gear)
    );

    // Output register and skid register
    logic                r_out_v;
    logic [RATIO_W-1:0]  r_out_ratio;
    logic [GEAR_W-1:0]   r_out_gear;
    logic [RATIO_W-1:0]  r_skid_ratio;
    logic [GEAR_W-1:0]   r_skid_gear;
    logic                w_out_free;

    assign w_out_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // pipeline frozen; drain skid once output is taken
            if (i_ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= w_g_v;
        end else if (w_g_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out_ratio <= r_skid_ratio;
                r_out_gear  <= r_skid_gear;
            end
        end else if (w_out_free) begin
            r_out_ratio <= w_g_ratio;
            r_out_gear  <= w_g_gear;
        end else begin
            r_skid_ratio <= w_g_ratio;
            r_skid_gear  <= w_g_gear;
        end
    end

    assign o_valid       = r_out_v;
    assign o_ratio_x100  = r_out_ratio;
    assign o_gear_number = r_out_gear;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_ready))
        else $error("skid loaded without an output stall");

    a_known_gear_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_gear_number != GEAR_UNKNOWN)) |-> (o_ratio_x100 != '0))
        else $error("known gear reported with a zero ratio");

    a_stall_freezes_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_f_v))
        else $error("front stage moved while the pipeline was held");

endmodule

// File: tb/gear_from_speed_and_rpm_unit_tb.sv
// Testbench for gear_from_speed_and_rpm_unit: self-checking, with a gear predictor
// and random idling on both channels. Depends on gfsr_pkg and the unit's RTL.
`timescale 1ns / 1ps

module gear_from_speed_and_rpm_unit_tb;
    import gfsr_pkg::*;

    localparam int unsigned AXLE_X100  = 394;
    localparam int unsigned CYCLE_CAP  = 300000;
    localparam int unsigned DRAIN_CYC  = 60;
    localparam int unsigned PHASE_ITEMS = 185;

    typedef struct {
        logic [SPD_W-1:0] spd;
        logic [RPM_W-1:0] rpm;
        logic [DIR_W-1:0] dir;
    } t_sample;

    typedef struct {
        logic [RATIO_W-1:0] ratio;
        logic [GEAR_W-1:0]  gear;
    } t_gear_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [SPD_W-1:0]   in_spd = '0;
    logic [RPM_W-1:0]   in_rpm = '0;
    logic [DIR_W-1:0]   in_dir = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [RATIO_W-1:0] out_ratio;
    logic [GEAR_W-1:0]  out_gear;

    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // Threshold registers as the predictor sees them, and the set to load next
    logic [CFG_W-1:0] thr_reg [8] = '{RST_FIRST_GEAR_MAX, RST_REVERSE_THRESHOLD,
        RST_THRESHOLD_FIRST, RST_THRESHOLD_SECOND, RST_THRESHOLD_THIRD,
        RST_THRESHOLD_FOURTH, RST_THRESHOLD_FIFTH, RST_THRESHOLD_SIXTH};
    logic [CFG_W-1:0] next_thr [8];

    t_sample      samples_pending[$];
    t_gear_result gears_expected[$];

    int unsigned n_queued  = 0;
    int unsigned n_taken   = 0;
    int unsigned n_errors  = 0;
    int unsigned cycles    = 0;

    logic in_xfer  = 1'b0;
    logic out_xfer = 1'b0;
    int   in_gap   = 0;
    int   out_hold = 0;
    logic in_steady  = 1'b0;
    logic out_steady = 1'b0;

    gear_from_speed_and_rpm_unit #(
        .AXLE_RATIO_X100 (AXLE_X100)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_vehicle_speed  (in_spd),
        .i_engine_speed   (in_rpm),
        .i_direction_code (in_dir),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_ratio_x100     (out_ratio),
        .o_gear_number    (out_gear),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Ratio x100 with truncating divisions, then the gear decision
    function automatic t_gear_result predict_gear(input logic [SPD_W-1:0] spd,
                                                  input logic [RPM_W-1:0] rpm,
                                                  input logic [DIR_W-1:0] dir);
        logic [63:0]  quot;
        logic [63:0]  scaled;
        t_gear_result res;
        scaled = '0;
        if (spd != '0) begin
            quot   = (64'(rpm) * 64'(RPM_SCALE)) / (64'(spd) * 64'(AXLE_X100));
            scaled = (quot * 64'(RATIO_MUL)) / 64'(RATIO_DIV);
        end
        res.ratio = (scaled >= 64'(RATIO_MAX_VAL)) ? RATIO_MAX : scaled[RATIO_W-1:0];
        res.gear  = GEAR_UNKNOWN;
        if (dir == DIR_REVERSE) begin
            if (res.ratio > thr_reg[CFG_REVERSE_THRESHOLD])
                res.gear = GEAR_REVERSE;
        end else if (res.ratio <= thr_reg[CFG_FIRST_GEAR_MAX]) begin
            // walk the ladder from the end so the first passing threshold wins
            for (int k = LADDER_N - 1; k >= 0; k--) begin
                if (res.ratio > thr_reg[int'(CFG_THRESHOLD_FIRST) + k])
                    res.gear = 8'(k + 1);
            end
        end
        return res;
    endfunction

    task automatic push_sample(input int spd, input int rpm, input int dir);
        t_sample s;
        s.spd = SPD_W'(spd);
        s.rpm = RPM_W'(rpm);
        s.dir = DIR_W'(dir);
        samples_pending.push_back(s);
        n_queued++;
    endtask

    // Block is idle once every queued sample is taken and every result is back
    task automatic wait_idle();
        while (n_taken != n_queued || gears_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_thresholds();
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(i);
            cfg_data <= next_thr[i];
            thr_reg[i] = next_thr[i];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Input driver: next sample after a transfer, with a drawn gap before it
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_xfer)) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (samples_pending.size() > 0) begin
                in_spd   <= samples_pending[0].spd;
                in_rpm   <= samples_pending[0].rpm;
                in_dir   <= samples_pending[0].dir;
                void'(samples_pending.pop_front());
                in_valid <= 1'b1;
                if ($urandom_range(0, 40) == 0)
                    in_steady <= ~in_steady;
                in_gap <= in_steady ? 0 : $urandom_range(0, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: hold ready low for a drawn number of cycles after a transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_xfer) begin
            if ($urandom_range(0, 40) == 0)
                out_steady <= ~out_steady;
            out_hold = out_steady ? 0 : $urandom_range(0, 5);
            out_ready <= (out_hold == 0);
            if (out_hold > 0)
                out_hold = out_hold - 1;
        end else if (out_hold > 0) begin
            out_ready <= 1'b0;
            out_hold = out_hold - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Input transfers: predict and store the expected result
    always @(posedge i_clk) begin
        in_xfer <= i_rst_n && in_valid && in_ready;
        if (i_rst_n && in_valid && in_ready) begin
            gears_expected.push_back(predict_gear(in_spd, in_rpm, in_dir));
            n_taken++;
        end
    end

    // Output transfers: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_gear_result want;
        out_xfer <= i_rst_n && out_valid && out_ready;
        if (i_rst_n && out_valid && out_ready) begin
            if (gears_expected.size() == 0) begin
                $error("unexpected result: ratio_x100 %0d gear_number %0d",
                       out_ratio, out_gear);
                n_errors++;
            end else begin
                want = gears_expected.pop_front();
                if (out_ratio !== want.ratio) begin
                    $error("ratio_x100: expected %0d, got %0d", want.ratio, out_ratio);
                    n_errors++;
                end
                if (out_gear !== want.gear) begin
                    $error("gear_number: expected %0d, got %0d", want.gear, out_gear);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int spd;
        int rpm;
        int target;
        int dir;
        int cur;
        int pick;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples on reset thresholds: standing vehicle, field extremes
        push_sample(0, 0, 0);
        push_sample(0, 65535, DIR_REVERSE);
        push_sample(0, 3000, 255);
        push_sample(255, 0, 0);
        push_sample(255, 65535, 0);
        push_sample(1, 65535, 0);
        push_sample(1, 65535, DIR_REVERSE);
        // saturation edge at speed 3
        push_sample(3, 59961, 0);
        push_sample(3, 59962, 0);
        push_sample(3, 59963, 0);
        // across the ladder at speed 100: below sixth, gears 6..1, above first max
        push_sample(100, 1220, 0);
        push_sample(100, 1830, 0);
        push_sample(100, 2290, 0);
        push_sample(100, 3050, 0);
        push_sample(100, 4575, 0);
        push_sample(100, 6100, 0);
        push_sample(100, 10670, 0);
        push_sample(100, 15250, 0);
        // reverse above and below threshold; neighbors and inverse of reverse code
        push_sample(100, 12000, DIR_REVERSE);
        push_sample(100, 3000, DIR_REVERSE);
        push_sample(100, 6100, 3);
        push_sample(100, 6100, 5);
        push_sample(100, 12000, 8'hFB);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: for (int i = 0; i < 8; i++) next_thr[i] = '0;
                    2: for (int i = 0; i < 8; i++) next_thr[i] = '1;
                    3: begin
                        // descending ladder, equal neighbors allowed
                        cur = $urandom_range(300, 700);
                        next_thr[CFG_FIRST_GEAR_MAX]    = CFG_W'(cur + $urandom_range(0, 200));
                        next_thr[CFG_REVERSE_THRESHOLD] = CFG_W'($urandom_range(0, 600));
                        for (int k = 0; k < LADDER_N; k++) begin
                            next_thr[int'(CFG_THRESHOLD_FIRST) + k] = CFG_W'(cur);
                            cur = cur - $urandom_range(0, cur / 3);
                        end
                    end
                    4: for (int i = 0; i < 8; i++) next_thr[i] = CFG_W'($urandom_range(0, 65535));
                    default: begin
                        // reset ladder, but with no upper cutoff
                        next_thr[CFG_FIRST_GEAR_MAX]    = '1;
                        next_thr[CFG_REVERSE_THRESHOLD] = RST_REVERSE_THRESHOLD;
                        next_thr[CFG_THRESHOLD_FIRST]   = RST_THRESHOLD_FIRST;
                        next_thr[CFG_THRESHOLD_SECOND]  = RST_THRESHOLD_SECOND;
                        next_thr[CFG_THRESHOLD_THIRD]   = RST_THRESHOLD_THIRD;
                        next_thr[CFG_THRESHOLD_FOURTH]  = RST_THRESHOLD_FOURTH;
                        next_thr[CFG_THRESHOLD_FIFTH]   = RST_THRESHOLD_FIFTH;
                        next_thr[CFG_THRESHOLD_SIXTH]   = RST_THRESHOLD_SIXTH;
                    end
                endcase
                load_thresholds();
            end

            // Mostly plausible driving points, plus standing and raw random samples
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                dir  = ($urandom_range(0, 3) == 0) ? int'(DIR_REVERSE) : $urandom_range(0, 255);
                if (pick < 65) begin
                    spd    = $urandom_range(5, 200);
                    target = $urandom_range(0, 600);
                    rpm    = target * spd * 305 / 1000;
                    if (rpm > 65535)
                        rpm = 65535;
                end else if (pick < 75) begin
                    spd = 0;
                    rpm = $urandom_range(0, 65535);
                end else begin
                    spd = $urandom_range(0, 255);
                    rpm = $urandom_range(0, 65535);
                end
                push_sample(spd, rpm, dir);
            end
        end

        wait_idle();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0 && gears_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
src/gfsr_pkg.sv
src/gfsr_div.sv
src/gfsr_scale.sv
src/gfsr_gear.sv
src/gear_from_speed_and_rpm_unit.sv
tb/gear_from_speed_and_rpm_unit_tb.sv
